[src/rpt_pkg.sv]
package rpt_pkg;

    localparam int ENTRIES = 32;
    localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int ADDR_W  = 14;
    localparam int PKT_W   = 48;
    localparam int WORD_W  = ADDR_W + PKT_W;
    localparam int OP_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_UPDATE  = 2'd0,
        OP_REFRESH = 2'd1,
        OP_LOOKUP  = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HEAD,
        ST_DONE
    } state_t;

    // (head + offset) mod ENTRIES, with head < ENTRIES and offset <= ENTRIES
    function automatic logic [SLOT_W-1:0] wrap_slot(
        input logic [SLOT_W-1:0] head,
        input logic [CNT_W-1:0]  offset
    );
        logic [CNT_W+SLOT_W-1:0] sum;
        sum = (CNT_W + SLOT_W)'(head) + (CNT_W + SLOT_W)'(offset);
        if (sum >= (CNT_W + SLOT_W)'(ENTRIES))
        begin
            sum = sum - (CNT_W + SLOT_W)'(ENTRIES);
        end
        return sum[SLOT_W-1:0];
    endfunction

endpackage

[src/rpt_ram.sv]
module rpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/refresh_packet_table_core.sv]
// Channel | Dir | tdata (low bit up)                                  | tuser
// s_*     | in  | loco_address[13:0], packet_data[61:14], pad to 64    | op[1:0]
// m_*     | out | out_address[13:0], out_packet[61:14],
//         |     | entry_count[67:62], pad to 72                         | found, overflow
//
// Update and lookup scan the ring through the slot RAM read port, one entry per
// cycle. Refresh reads the head entry on acceptance and writes it back at the
// tail; clear resets head and count on acceptance.
// One transaction is in flight at a time; the result register lets the next
// transaction enter while a result waits on m_tready.
// Reset empties the ring at once; slot contents stay undefined until written.
module refresh_packet_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // loco_address, packet_data
    input  logic [1:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // out_address, out_packet, entry_count
    output logic [1:0]  m_tuser    // found, overflow
);

    localparam int SW = rpt_pkg::SLOT_W;
    localparam int CW = rpt_pkg::CNT_W;
    localparam int AW = rpt_pkg::ADDR_W;
    localparam int PW = rpt_pkg::PKT_W;
    localparam int WW = rpt_pkg::WORD_W;

    rpt_pkg::state_t state_reg, state_next;
    rpt_pkg::op_t    op_reg, op_next;
    logic [AW-1:0]   key_reg, key_next;
    logic [PW-1:0]   pkt_reg, pkt_next;
    logic [SW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   scan_idx_reg, scan_idx_next;
    logic            pend_reg, pend_next;
    logic [SW-1:0]   pend_slot_reg, pend_slot_next;

    logic            res_found_reg, res_found_next;
    logic            res_ovf_reg, res_ovf_next;
    logic [AW-1:0]   res_addr_reg, res_addr_next;
    logic [PW-1:0]   res_pkt_reg, res_pkt_next;

    logic            m_tvalid_reg, m_tvalid_next;
    logic [71:0]     m_tdata_reg, m_tdata_next;
    logic [1:0]      m_tuser_reg, m_tuser_next;

    logic            ram_we;
    logic [SW-1:0]   ram_waddr;
    logic [WW-1:0]   ram_wdata;
    logic [SW-1:0]   ram_raddr;
    logic [WW-1:0]   ram_rdata;

    logic [AW-1:0]   rd_addr;
    logic [PW-1:0]   rd_pkt;
    logic            scan_hit;
    logic            scan_miss;
    logic            out_free;
    logic            s_fire;

    assign rd_addr   = ram_rdata[WW-1:PW];
    assign rd_pkt    = ram_rdata[PW-1:0];
    assign scan_hit  = pend_reg && (rd_addr == key_reg);
    assign scan_miss = !pend_reg && (scan_idx_reg == count_reg);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == rpt_pkg::ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    rpt_ram #(
        .WIDTH (WW),
        .DEPTH (rpt_pkg::ENTRIES)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rpt_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    case (rpt_pkg::op_t'(s_tuser))
                        rpt_pkg::OP_UPDATE:  state_next = rpt_pkg::ST_SCAN;
                        rpt_pkg::OP_LOOKUP:  state_next = rpt_pkg::ST_SCAN;
                        rpt_pkg::OP_REFRESH: state_next = rpt_pkg::ST_HEAD;
                        default:             state_next = rpt_pkg::ST_DONE;
                    endcase
                end
            end
            rpt_pkg::ST_SCAN:
            begin
                if (scan_hit || scan_miss)
                begin
                    state_next = rpt_pkg::ST_DONE;
                end
            end
            rpt_pkg::ST_HEAD:
            begin
                state_next = rpt_pkg::ST_DONE;
            end
            rpt_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = rpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rpt_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        op_next        = op_reg;
        key_next       = key_reg;
        pkt_next       = pkt_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        pend_next      = 1'b0;
        pend_slot_next = pend_slot_reg;
        res_found_next = res_found_reg;
        res_ovf_next   = res_ovf_reg;
        res_addr_next  = res_addr_reg;
        res_pkt_next   = res_pkt_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        ram_we         = 1'b0;
        ram_waddr      = pend_slot_reg;
        ram_wdata      = {key_reg, pkt_reg};
        ram_raddr      = head_reg;

        case (state_reg)
            rpt_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    op_next        = rpt_pkg::op_t'(s_tuser);
                    key_next       = s_tdata[AW-1:0];
                    pkt_next       = s_tdata[AW+PW-1:AW];
                    scan_idx_next  = '0;
                    res_found_next = 1'b0;
                    res_ovf_next   = 1'b0;
                    res_addr_next  = '0;
                    res_pkt_next   = '0;
                    if (rpt_pkg::op_t'(s_tuser) == rpt_pkg::OP_CLEAR)
                    begin
                        head_next  = '0;
                        count_next = '0;
                    end
                end
            end
            rpt_pkg::ST_SCAN:
            begin
                if (scan_hit)
                begin
                    if (op_reg == rpt_pkg::OP_UPDATE)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = pend_slot_reg;
                    end
                    else
                    begin
                        res_found_next = 1'b1;
                        res_addr_next  = rd_addr;
                        res_pkt_next   = rd_pkt;
                    end
                end
                else if (scan_miss)
                begin
                    if (op_reg == rpt_pkg::OP_UPDATE)
                    begin
                        if (count_reg < CW'(rpt_pkg::ENTRIES))
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = rpt_pkg::wrap_slot(head_reg, count_reg);
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            res_ovf_next = 1'b1;
                        end
                    end
                end
                else if (scan_idx_reg < count_reg)
                begin
                    // keep one read in flight each cycle
                    ram_raddr      = rpt_pkg::wrap_slot(head_reg, scan_idx_reg);
                    pend_next      = 1'b1;
                    pend_slot_next = ram_raddr;
                    scan_idx_next  = scan_idx_reg + CW'(1);
                end
            end
            rpt_pkg::ST_HEAD:
            begin
                // head entry was read on acceptance; move it to the tail
                if (count_reg != '0)
                begin
                    res_found_next = 1'b1;
                    res_addr_next  = rd_addr;
                    res_pkt_next   = rd_pkt;
                    ram_we         = 1'b1;
                    ram_waddr      = rpt_pkg::wrap_slot(head_reg, count_reg);
                    ram_wdata      = ram_rdata;
                    head_next      = rpt_pkg::wrap_slot(head_reg, CW'(1));
                end
            end
            rpt_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(72 - AW - PW - 6){1'b0}}, 6'(count_reg),
                                     res_pkt_reg, res_addr_reg};
                    m_tuser_next  = {res_ovf_reg, res_found_reg};
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rpt_pkg::ST_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        pkt_reg       <= pkt_next;
        scan_idx_reg  <= scan_idx_next;
        pend_slot_reg <= pend_slot_next;
        res_found_reg <= res_found_next;
        res_ovf_reg   <= res_ovf_next;
        res_addr_reg  <= res_addr_next;
        res_pkt_reg   <= res_pkt_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

endmodule
